// ===== design/srp_pkg.sv =====
// Shared types and constants for the skyline rectangle packer.
// No dependencies.
package srp_pkg;

	localparam int FIELD_W   = 13;
	localparam int CFG_IDX_W = 2;
	localparam int DIM_MIN   = 3;
	localparam int DIM_RESET = 512;

	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_H = 2'd1;

	typedef enum logic [1:0] {
		ST_PLACED = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

endpackage

// ===== design/srp_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module srp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/srp_store.sv =====
// Ping-pong segment table: one bank is read while the rebuilt table goes to the other.
// Depends on srp_ram. A fresh table reads as the single initial segment.
module srp_store #(
	parameter int WIDTH = 37,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     reinit,
	input  logic                     swap,
	input  logic [WIDTH-1:0]         init_word,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);
	logic             bank_q;
	logic             bank_rd_q;
	logic             fresh_q;
	logic             fresh_rd_q;
	logic [WIDTH-1:0] rdata0;
	logic [WIDTH-1:0] rdata1;

	srp_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_bank0 (
		.clk(clk), .we(wr_en && bank_q), .waddr(wr_addr), .wdata(wr_data),
		.raddr(rd_addr), .rdata(rdata0)
	);

	srp_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_bank1 (
		.clk(clk), .we(wr_en && !bank_q), .waddr(wr_addr), .wdata(wr_data),
		.raddr(rd_addr), .rdata(rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= 1'b0;
			bank_rd_q  <= 1'b0;
			fresh_q    <= 1'b1;
			fresh_rd_q <= 1'b1;
		end else begin
			bank_rd_q  <= bank_q;
			fresh_rd_q <= fresh_q;
			if (reinit) begin
				fresh_q <= 1'b1;
			end else if (swap) begin
				fresh_q <= 1'b0;
				bank_q  <= !bank_q;
			end
		end
	end

	// a fresh table only ever holds entry 0
	assign rd_data = fresh_rd_q ? init_word : (bank_rd_q ? rdata1 : rdata0);
endmodule

// ===== design/skyline_rect_packer.sv =====
// Skyline rectangle packer, top level: request sequencer, fit scan and table rebuild.
// Depends on srp_pkg and srp_store (which uses srp_ram).
//
// Usage: one request word (req_width, req_height) on the in channel gives one
// result word (place_x, place_y, granted_width, granted_height, status) on the
// out channel. Requests are taken one at a time; in_ready is high only when no
// request is in flight. Configuration writes (atlas_width, atlas_height) are
// taken at any edge with cfg_we high, are saturated to [3, 2^COORD_BITS] and
// put the skyline back to its single initial segment.
// A zero-size request has its result valid the cycle after it is taken.
// Otherwise the fit scan reads one segment at a time, a read state then a wait
// state, through the single read port of the segment memory; for each anchor
// it reads the anchor, then the segments that the anchor's rectangle spans.
// A placement then rebuilds the table into the other bank, one read per segment.
// Reset: atlas sizes 512, one segment, no clearing pass. If the receiver
// stalls, the result is held and no new request is taken.
module skyline_rect_packer #(
	parameter int MAX_SEGMENTS = 256,
	parameter int COORD_BITS   = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [srp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srp_pkg::FIELD_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [srp_pkg::FIELD_W-1:0]   req_width,
	input  logic [srp_pkg::FIELD_W-1:0]   req_height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [srp_pkg::FIELD_W-1:0] place_x,
	output logic signed [srp_pkg::FIELD_W-1:0] place_y,
	output logic [srp_pkg::FIELD_W-1:0]   granted_width,
	output logic [srp_pkg::FIELD_W-1:0]   granted_height,
	output srp_pkg::status_t              status
);
	import srp_pkg::*;

	localparam int IW   = $clog2(MAX_SEGMENTS);
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int XW   = COORD_BITS;
	localparam int WW   = COORD_BITS + 1;
	localparam int SEGW = 2 * XW + WW;
	localparam int ZW   = ((WW > FIELD_W) ? WW : FIELD_W) + 2;
	localparam logic [ZW-1:0] DIM_MAX_Z = ZW'(1 << COORD_BITS);
	localparam logic [CW-1:0] CNT_FULL  = CW'(MAX_SEGMENTS);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_ARD   = 10'b0000000010,
		S_AWT   = 10'b0000000100,
		S_IRD   = 10'b0000001000,
		S_IWT   = 10'b0000010000,
		S_DONE  = 10'b0000100000,
		S_BRD   = 10'b0001000000,
		S_BWT   = 10'b0010000000,
		S_FLUSH = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [ZW-1:0] aw_q, ah_q;
	logic [ZW-1:0] req_w_q, req_h_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] a_q;
	logic [CW-1:0] i_q;
	logic [ZW-1:0] y_q;
	logic signed [ZW-1:0] left_q;
	logic [XW-1:0] anc_x_q;
	logic [WW-1:0] anc_w_q;
	logic          best_v_q;
	logic [IW-1:0] best_q;
	logic [ZW-1:0] best_top_q;
	logic [WW-1:0] best_w_q;
	logic [XW-1:0] bx_q;
	logic [ZW-1:0] by_q;
	logic [CW-1:0] r_q;
	logic          ins_done_q, trim_q;
	logic [ZW-1:0] edge_q;
	logic          pend_v_q;
	logic [XW-1:0] pend_x_q, pend_y_q;
	logic [WW-1:0] pend_w_q;
	logic [IW-1:0] wptr_q;
	logic [FIELD_W-1:0] px_q, py_q, gw_q, gh_q;
	status_t       st_q;

	logic [SEGW-1:0] rd_data, init_word, wr_data;
	logic [IW-1:0]   rd_addr;
	logic            wr_en, swap, reinit;
	logic [XW-1:0]   rx, ry;
	logic [WW-1:0]   rw;

	logic [ZW-1:0]   cfg_z, cfg_clamp;
	logic            last_anchor, ins_hit, cut_hit;
	logic [ZW-1:0]   ny, ntop;
	logic signed [ZW-1:0] nl, cut_w;
	logic            better;
	logic            feed_v;
	logic [XW-1:0]   feed_x, feed_y;
	logic [WW-1:0]   feed_w;
	logic            feed_new;

	assign rx = rd_data[SEGW-1 -: XW];
	assign ry = rd_data[WW+XW-1 -: XW];
	assign rw = rd_data[WW-1:0];

	assign init_word = {XW'(1), XW'(1), WW'(aw_q - ZW'(2))};
	assign reinit    = cfg_we && (cfg_index == REG_ATLAS_W || cfg_index == REG_ATLAS_H);
	assign swap      = (state_q == S_FLUSH);

	assign cfg_z     = ZW'(cfg_data);
	assign cfg_clamp = (cfg_z < ZW'(DIM_MIN)) ? ZW'(DIM_MIN) :
	                   (cfg_z > DIM_MAX_Z) ? DIM_MAX_Z : cfg_z;

	always_comb begin
		case (state_q)
			S_ARD:   rd_addr = a_q;
			S_IRD:   rd_addr = i_q[IW-1:0];
			S_BRD:   rd_addr = r_q[IW-1:0];
			default: rd_addr = '0;
		endcase
	end

	assign last_anchor = (CW'(a_q) + CW'(1) == cnt_q);
	assign ny   = (ZW'(ry) > y_q) ? ZW'(ry) : y_q;
	assign ntop = ny + req_h_q;
	assign nl   = left_q - $signed(ZW'(rw));
	assign better = !best_v_q || (ntop < best_top_q) ||
	                (ntop == best_top_q && anc_w_q < best_w_q);

	assign ins_hit = !ins_done_q && (r_q[IW-1:0] == best_q);
	assign cut_w   = $signed(ZW'(rw)) - $signed(edge_q - ZW'(rx));
	assign cut_hit = trim_q && (ZW'(rx) < edge_q);

	// merge feed: earlier old segments, new one, later ones cut at its right edge
	always_comb begin
		feed_v = 1'b0;
		feed_x = bx_q;
		feed_y = XW'(by_q + req_h_q);
		feed_w = WW'(req_w_q);
		if (state_q == S_BRD && ins_hit) begin
			feed_v = 1'b1;
		end else if (state_q == S_BWT) begin
			if (cut_hit) begin
				feed_v = (cut_w > 0);
				feed_x = XW'(edge_q);
				feed_y = ry;
				feed_w = WW'(cut_w);
			end else begin
				feed_v = 1'b1;
				feed_x = rx;
				feed_y = ry;
				feed_w = rw;
			end
		end
	end

	assign feed_new = feed_v && !(pend_v_q && pend_y_q == feed_y);
	assign wr_en    = (feed_new && pend_v_q) || (state_q == S_FLUSH);
	assign wr_data  = {pend_x_q, pend_y_q, pend_w_q};

	srp_store #(.WIDTH(SEGW), .DEPTH(MAX_SEGMENTS)) u_store (
		.clk(clk), .arst_n(arst_n), .reinit(reinit), .swap(swap),
		.init_word(init_word), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(wptr_q), .wr_data(wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			aw_q       <= ZW'(DIM_RESET);
			ah_q       <= ZW'(DIM_RESET);
			cnt_q      <= CW'(1);
			best_v_q   <= 1'b0;
			ins_done_q <= 1'b0;
			trim_q     <= 1'b0;
			pend_v_q   <= 1'b0;
			wptr_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_ATLAS_W) aw_q <= cfg_clamp;
			if (cfg_we && cfg_index == REG_ATLAS_H) ah_q <= cfg_clamp;
			if (reinit) cnt_q <= CW'(1);

			if (feed_v) begin
				if (!feed_new) begin
					pend_w_q <= pend_w_q + feed_w;
				end else begin
					pend_x_q <= feed_x;
					pend_y_q <= feed_y;
					pend_w_q <= feed_w;
					pend_v_q <= 1'b1;
					if (pend_v_q) wptr_q <= wptr_q + IW'(1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_w_q  <= ZW'(req_width);
						req_h_q  <= ZW'(req_height);
						a_q      <= '0;
						best_v_q <= 1'b0;
						if (req_width == '0 || req_height == '0) begin
							px_q    <= '1;
							py_q    <= '1;
							gw_q    <= '0;
							gh_q    <= '0;
							st_q    <= ST_NOFIT;
							state_q <= S_OUT;
						end else begin
							state_q <= S_ARD;
						end
					end
				end
				S_ARD: state_q <= S_AWT;
				S_AWT: begin
					if (ZW'(rx) + req_w_q > aw_q - ZW'(1)) begin
						a_q     <= a_q + IW'(1);
						state_q <= last_anchor ? S_DONE : S_ARD;
					end else begin
						y_q     <= ZW'(ry);
						left_q  <= $signed(req_w_q);
						i_q     <= CW'(a_q);
						anc_x_q <= rx;
						anc_w_q <= rw;
						state_q <= S_IRD;
					end
				end
				S_IRD: begin
					if (i_q >= cnt_q) begin
						a_q     <= a_q + IW'(1);
						state_q <= last_anchor ? S_DONE : S_ARD;
					end else begin
						state_q <= S_IWT;
					end
				end
				S_IWT: begin
					if (ntop > ah_q - ZW'(1)) begin
						a_q     <= a_q + IW'(1);
						state_q <= last_anchor ? S_DONE : S_ARD;
					end else begin
						y_q    <= ny;
						left_q <= nl;
						i_q    <= i_q + CW'(1);
						if (nl <= 0) begin
							if (better) begin
								best_v_q   <= 1'b1;
								best_q     <= a_q;
								best_top_q <= ntop;
								best_w_q   <= anc_w_q;
								bx_q       <= anc_x_q;
								by_q       <= ny;
							end
							a_q     <= a_q + IW'(1);
							state_q <= last_anchor ? S_DONE : S_ARD;
						end else begin
							state_q <= S_IRD;
						end
					end
				end
				S_DONE: begin
					if (!best_v_q || cnt_q == CNT_FULL) begin
						px_q    <= '1;
						py_q    <= '1;
						gw_q    <= '0;
						gh_q    <= '0;
						st_q    <= best_v_q ? ST_FULL : ST_NOFIT;
						state_q <= S_OUT;
					end else begin
						r_q        <= '0;
						ins_done_q <= 1'b0;
						trim_q     <= 1'b0;
						pend_v_q   <= 1'b0;
						wptr_q     <= '0;
						state_q    <= S_BRD;
					end
				end
				S_BRD: begin
					if (ins_hit) begin
						ins_done_q <= 1'b1;
						trim_q     <= 1'b1;
						edge_q     <= ZW'(bx_q) + req_w_q;
					end else begin
						state_q <= S_BWT;
					end
				end
				S_BWT: begin
					trim_q  <= cut_hit && (cut_w <= 0);
					r_q     <= r_q + CW'(1);
					state_q <= (r_q + CW'(1) == cnt_q) ? S_FLUSH : S_BRD;
				end
				S_FLUSH: begin
					cnt_q   <= CW'(wptr_q) + CW'(1);
					px_q    <= FIELD_W'(bx_q);
					py_q    <= FIELD_W'(by_q);
					gw_q    <= FIELD_W'(req_w_q);
					gh_q    <= FIELD_W'(req_h_q);
					st_q    <= ST_PLACED;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = (state_q == S_OUT);
	assign place_x        = $signed(px_q);
	assign place_y        = $signed(py_q);
	assign granted_width  = gw_q;
	assign granted_height = gh_q;
	assign status         = st_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request taken while a result is pending");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CNT_FULL)
		else $error("segment count out of range");

	a_placed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_PLACED |-> granted_width != '0 && granted_height != '0)
		else $error("placement with zero size");

endmodule
